// File: hdl/tfn_pkg.sv
`timescale 1ns / 1ps

package tfn_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 14;
    localparam int OUT_W      = FRAC_W + 2;
    localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    // Datapath widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int POS_W   = $clog2(AREA_W);
    localparam int WIN_MSB = 29;                // largest magnitude lands in [2^29, 2^30)
    localparam int R_W     = WIN_MSB + 1;
    localparam int SQ_W    = 2 * R_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int Q_W     = FRAC_W + 1;
    localparam int NUM_W   = ROOT_W + FRAC_W + 1;

    // Sideband that travels with each triangle
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       last;
    } side_t;

    // Normalized magnitudes plus sideband
    typedef struct packed {
        logic [2:0][R_W-1:0] r;
        side_t               side;
    } pay_t;

    // Position of the highest set bit
    function automatic logic [POS_W-1:0] msb_pos(input logic [AREA_W-1:0] v);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < AREA_W; i++)
        begin
            if (v[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: hdl/tfn_front.sv
`timescale 1ns / 1ps

module tfn_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [9*tfn_pkg::COORD_W-1:0]  in_data,
    input  logic                           in_last,
    output logic                           out_valid,
    output logic [tfn_pkg::SUM_W-1:0]      out_sum,
    output tfn_pkg::pay_t                  out_pay
);

    localparam int STAGES = 8;

    logic signed [tfn_pkg::COORD_W-1:0] crd [9];

    logic signed [tfn_pkg::DIFF_W-1:0] d1_reg [3];
    logic signed [tfn_pkg::DIFF_W-1:0] d2_reg [3];
    logic signed [tfn_pkg::PROD_W-1:0] p_reg [3];
    logic signed [tfn_pkg::PROD_W-1:0] q_reg [3];
    logic signed [tfn_pkg::AREA_W-1:0] area_reg [3];
    logic [tfn_pkg::AREA_W-1:0]        mag4_reg [3];
    logic [tfn_pkg::AREA_W-1:0]        max_reg;
    logic [tfn_pkg::AREA_W-1:0]        mag5_reg [3];
    logic [tfn_pkg::POS_W-1:0]         pos_reg;
    logic [tfn_pkg::R_W-1:0]           r_reg [3];
    logic [tfn_pkg::SQ_W-1:0]          sq_reg [3];
    logic [tfn_pkg::SUM_W-1:0]         sum_reg;
    logic [2:0]                        last_reg;
    tfn_pkg::side_t                    side4_reg, side5_reg, side6_reg;
    tfn_pkg::pay_t                     pay7_reg, pay8_reg;
    logic [STAGES-1:0]                 vld_reg;
    logic [STAGES-1:0]                 vld_next;

    logic [tfn_pkg::AREA_W-1:0] mag_c [3];
    logic [tfn_pkg::AREA_W-1:0] max_c;
    logic [tfn_pkg::R_W-1:0]    r_c [3];

    // Unpack coordinates: a_x a_y a_z b_x ... c_z from the low bits up
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            crd[k] = $signed(in_data[k*tfn_pkg::COORD_W +: tfn_pkg::COORD_W]);
        end
    end

    // Magnitudes and their maximum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_c[i] = area_reg[i][tfn_pkg::AREA_W-1] ? tfn_pkg::AREA_W'(-area_reg[i])
                                                      : tfn_pkg::AREA_W'(area_reg[i]);
        end
        max_c = mag_c[0];
        if (mag_c[1] > max_c)
        begin
            max_c = mag_c[1];
        end
        if (mag_c[2] > max_c)
        begin
            max_c = mag_c[2];
        end
    end

    // Common shift into the window
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg > tfn_pkg::POS_W'(tfn_pkg::WIN_MSB))
            begin
                r_c[i] = tfn_pkg::R_W'(mag5_reg[i] >>
                                       (pos_reg - tfn_pkg::POS_W'(tfn_pkg::WIN_MSB)));
            end
            else
            begin
                r_c[i] = tfn_pkg::R_W'(mag5_reg[i] <<
                                       (tfn_pkg::POS_W'(tfn_pkg::WIN_MSB) - pos_reg));
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edge vectors B-A and C-A
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= tfn_pkg::DIFF_W'(crd[3+i]) - tfn_pkg::DIFF_W'(crd[i]);
                d2_reg[i] <= tfn_pkg::DIFF_W'(crd[6+i]) - tfn_pkg::DIFF_W'(crd[i]);
            end
            last_reg <= {last_reg[1:0], in_last};

            // cross product terms
            p_reg[0] <= d1_reg[1] * d2_reg[2];
            q_reg[0] <= d1_reg[2] * d2_reg[1];
            p_reg[1] <= d1_reg[2] * d2_reg[0];
            q_reg[1] <= d1_reg[0] * d2_reg[2];
            p_reg[2] <= d1_reg[0] * d2_reg[1];
            q_reg[2] <= d1_reg[1] * d2_reg[0];

            // area vector
            for (int i = 0; i < 3; i++)
            begin
                area_reg[i] <= tfn_pkg::AREA_W'(p_reg[i]) - tfn_pkg::AREA_W'(q_reg[i]);
            end

            // magnitudes, signs, zero test
            for (int i = 0; i < 3; i++)
            begin
                mag4_reg[i]      <= mag_c[i];
                side4_reg.neg[i] <= area_reg[i][tfn_pkg::AREA_W-1];
            end
            max_reg         <= max_c;
            side4_reg.degen <= (area_reg[0] == '0) && (area_reg[1] == '0) &&
                               (area_reg[2] == '0);
            side4_reg.last  <= last_reg[2];

            // leading bit of the maximum
            mag5_reg  <= mag4_reg;
            pos_reg   <= tfn_pkg::msb_pos(max_reg);
            side5_reg <= side4_reg;

            // shifted magnitudes
            r_reg     <= r_c;
            side6_reg <= side5_reg;

            // squares
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= r_reg[i] * r_reg[i];
                pay7_reg.r[i] <= r_reg[i];
            end
            pay7_reg.side <= side6_reg;

            // sum of squares
            sum_reg  <= tfn_pkg::SUM_W'(sq_reg[0]) + tfn_pkg::SUM_W'(sq_reg[1]) +
                        tfn_pkg::SUM_W'(sq_reg[2]);
            pay8_reg <= pay7_reg;
        end
    end

    // Valid chain
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_sum   = sum_reg;
    assign out_pay   = pay8_reg;

endmodule

// File: hdl/tfn_sqrt.sv
`timescale 1ns / 1ps

module tfn_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tfn_pkg::SUM_W-1:0]    in_sum,
    input  tfn_pkg::pay_t                in_pay,
    output logic                         out_valid,
    output logic [tfn_pkg::ROOT_W-1:0]   out_root,
    output tfn_pkg::pay_t                out_pay
);

    localparam int N = tfn_pkg::ROOT_W;

    logic [tfn_pkg::SUM_W-1:0]  s_reg    [N];
    logic [tfn_pkg::REM_W-1:0]  rem_reg  [N];
    logic [tfn_pkg::ROOT_W-1:0] root_reg [N];
    tfn_pkg::pay_t              pay_reg  [N];
    logic [N-1:0]               vld_reg;

    // One root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [tfn_pkg::SUM_W-1:0]  cur_s;
        logic [tfn_pkg::REM_W-1:0]  cur_rem;
        logic [tfn_pkg::ROOT_W-1:0] cur_root;
        tfn_pkg::pay_t              cur_pay;
        logic                       cur_vld;
        logic [tfn_pkg::REM_W+1:0]  part;
        logic [tfn_pkg::REM_W+1:0]  trial;

        if (k == 0)
        begin : g_head
            assign cur_s    = in_sum;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_pay  = in_pay;
            assign cur_vld  = in_valid;
        end
        else
        begin : g_body
            assign cur_s    = s_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_pay  = pay_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        assign part  = {cur_rem, cur_s[tfn_pkg::SUM_W-1 -: 2]};
        assign trial = (tfn_pkg::REM_W + 2)'({cur_root, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (part >= trial)
                begin
                    rem_reg[k]  <= tfn_pkg::REM_W'(part - trial);
                    root_reg[k] <= {cur_root[tfn_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= tfn_pkg::REM_W'(part);
                    root_reg[k] <= {cur_root[tfn_pkg::ROOT_W-2:0], 1'b0};
                end
                s_reg[k]   <= cur_s << 2;
                pay_reg[k] <= cur_pay;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= cur_vld;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_pay   = pay_reg[N-1];

endmodule

// File: hdl/tfn_div.sv
`timescale 1ns / 1ps

module tfn_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [tfn_pkg::ROOT_W-1:0]      in_root,
    input  tfn_pkg::pay_t                   in_pay,
    output logic                            out_valid,
    output logic [2:0][tfn_pkg::Q_W-1:0]    out_q,
    output tfn_pkg::side_t                  out_side
);

    localparam int N = tfn_pkg::Q_W;

    logic [2:0][tfn_pkg::NUM_W-1:0] rem_reg  [N];
    logic [2:0][tfn_pkg::Q_W-1:0]   q_reg    [N];
    logic [tfn_pkg::ROOT_W-1:0]     l_reg    [N];
    tfn_pkg::side_t                 side_reg [N];
    logic [N-1:0]                   vld_reg;

    // Restoring division, one quotient bit per stage, three lanes share the divisor
    for (genvar t = 0; t < N; t++)
    begin : g_stage
        localparam int J = N - 1 - t;

        logic [2:0][tfn_pkg::NUM_W-1:0] cur_rem;
        logic [2:0][tfn_pkg::Q_W-1:0]   cur_q;
        logic [tfn_pkg::ROOT_W-1:0]     cur_l;
        tfn_pkg::side_t                 cur_side;
        logic                           cur_vld;
        logic [tfn_pkg::NUM_W:0]        dsh;

        if (t == 0)
        begin : g_head
            // numerator r * 2^F + floor(L/2)
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign cur_rem[i] =
                    tfn_pkg::NUM_W'({in_pay.r[i], {tfn_pkg::FRAC_W{1'b0}}}) +
                    tfn_pkg::NUM_W'(in_root >> 1);
            end
            assign cur_q    = '0;
            assign cur_l    = in_root;
            assign cur_side = in_pay.side;
            assign cur_vld  = in_valid;
        end
        else
        begin : g_body
            assign cur_rem  = rem_reg[t-1];
            assign cur_q    = q_reg[t-1];
            assign cur_l    = l_reg[t-1];
            assign cur_side = side_reg[t-1];
            assign cur_vld  = vld_reg[t-1];
        end

        assign dsh = (tfn_pkg::NUM_W + 1)'(cur_l) << J;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, cur_rem[i]} >= dsh)
                    begin
                        rem_reg[t][i] <= tfn_pkg::NUM_W'({1'b0, cur_rem[i]} - dsh);
                        q_reg[t][i]   <= {cur_q[i][tfn_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[t][i] <= cur_rem[i];
                        q_reg[t][i]   <= {cur_q[i][tfn_pkg::Q_W-2:0], 1'b0};
                    end
                end
                l_reg[t]    <= cur_l;
                side_reg[t] <= cur_side;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[t] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[t] <= cur_vld;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// File: hdl/triangle_face_normal_unit.sv
`timescale 1ns / 1ps
// Face normal of one triangle (Newell area vector, normalized to Q1.14).
// Pipeline: front end, bitwise square root, bitwise division and an output register, in that order.
// Throughput: one triangle per cycle; the whole pipeline holds while the output stalls.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.

module triangle_face_normal_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
    input  logic [tfn_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: norm_x, norm_y, norm_z (16 bits each)
    output logic [tfn_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: degenerate
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);

    logic                            en;
    logic                            front_valid;
    logic [tfn_pkg::SUM_W-1:0]       front_sum;
    tfn_pkg::pay_t                   front_pay;
    logic                            sqrt_valid;
    logic [tfn_pkg::ROOT_W-1:0]      sqrt_root;
    tfn_pkg::pay_t                   sqrt_pay;
    logic                            div_valid;
    logic [2:0][tfn_pkg::Q_W-1:0]    div_q;
    tfn_pkg::side_t                  div_side;

    logic [2:0][tfn_pkg::OUT_W-1:0]  norm_c;
    logic [2:0][tfn_pkg::OUT_W-1:0]  norm_reg;
    logic                            degen_reg;
    logic                            last_reg;
    logic                            m_valid_reg;

    // Global advance: move when the output slot is free or being taken
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata[9*tfn_pkg::COORD_W-1:0]),
        .in_last   (s_tlast),
        .out_valid (front_valid),
        .out_sum   (front_sum),
        .out_pay   (front_pay)
    );

    tfn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_sum    (front_sum),
        .in_pay    (front_pay),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_pay   (sqrt_pay)
    );

    tfn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_root   (sqrt_root),
        .in_pay    (sqrt_pay),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    // Apply signs, zero out degenerate triangles
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_side.degen)
            begin
                norm_c[i] = '0;
            end
            else if (div_side.neg[i])
            begin
                norm_c[i] = tfn_pkg::OUT_W'(-tfn_pkg::OUT_W'(div_q[i]));
            end
            else
            begin
                norm_c[i] = tfn_pkg::OUT_W'(div_q[i]);
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg  <= norm_c;
            degen_reg <= div_side.degen;
            last_reg  <= div_side.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= div_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tfn_pkg::OUT_DATA_W'({norm_reg[2], norm_reg[1], norm_reg[0]});
    assign m_tuser  = degen_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    // quotients never exceed one in Q1.14
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && !div_side.degen |->
            (div_q[0] <= (tfn_pkg::Q_W'(1) << tfn_pkg::FRAC_W)) &&
            (div_q[1] <= (tfn_pkg::Q_W'(1) << tfn_pkg::FRAC_W)) &&
            (div_q[2] <= (tfn_pkg::Q_W'(1) << tfn_pkg::FRAC_W)))
        else $error("normal component above unit range");

    // degenerate results carry a zero vector
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0))
        else $error("degenerate triangle with nonzero normal");

    // a held pipeline does not move its valid bits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(div_valid))
        else $error("pipeline advanced during stall");
`endif

endmodule

// File: sim/triangle_face_normal_unit_tb.sv
`timescale 1ns / 1ps

module triangle_face_normal_unit_tb;

    localparam int LATENCY     = 55;
    localparam int WDOG_MAX    = 20000;
    localparam int HOLD_CYCLES = 200;

    typedef logic signed [tfn_pkg::COORD_W-1:0] coord_t;
    typedef logic signed [tfn_pkg::OUT_W-1:0]   norm_t;

    typedef struct {
        coord_t v[9];
        logic   last;
    } tri_t;

    typedef struct {
        norm_t n[3];
        logic  degen;
        logic  last;
    } normal_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [tfn_pkg::IN_DATA_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [tfn_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;

    normal_t pending_normals[$];
    int      mismatches   = 0;
    int      src_idle_pct;
    int      dst_idle_pct;
    int      hold_reqs    = 0;
    int      hold_seen    = 0;
    int      hold_cnt     = 0;
    int      quiet_cycles = 0;

    triangle_face_normal_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv >>= 2;
        end
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Newell area vector, normalized to unit length
    function automatic normal_t face_normal(input tri_t t);
        normal_t res;
        longint area[3];
        longint p[3];
        longint q[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sumsq;
        longint unsigned len;
        longint unsigned quo;
        area = '{0, 0, 0};
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p[i] = t.v[e * 3 + i];
                q[i] = t.v[((e + 1) % 3) * 3 + i];
            end
            area[0] += p[1] * q[2] - q[1] * p[2];
            area[1] += p[2] * q[0] - q[2] * p[0];
            area[2] += p[0] * q[1] - q[0] * p[1];
        end
        res.last = t.last;
        if (area[0] == 0 && area[1] == 0 && area[2] == 0)
        begin
            res.n = '{0, 0, 0};
            res.degen = 1'b1;
            return res;
        end
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (area[i] < 0) ? -area[i] : area[i];
            if (mag[i] > peak)
            begin
                peak = mag[i];
            end
        end
        // slide into the window [2^29, 2^30)
        while (peak >= (64'd1 << 30))
        begin
            peak >>= 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] >>= 1;
            end
        end
        while (peak < (64'd1 << 29))
        begin
            peak <<= 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] <<= 1;
            end
        end
        sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            quo = ((mag[i] << tfn_pkg::FRAC_W) + (len >> 1)) / len;
            if (area[i] < 0)
            begin
                quo = -quo;
            end
            res.n[i] = quo[tfn_pkg::OUT_W-1:0];
        end
        res.degen = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Send one triangle and queue its expected normal; valid stays up for the next one
    task automatic send_triangle(input tri_t t);
        logic [tfn_pkg::IN_DATA_W-1:0] packed_data;
        packed_data = '0;
        for (int i = 0; i < 9; i++)
        begin
            packed_data[i * tfn_pkg::COORD_W +: tfn_pkg::COORD_W] = t.v[i];
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packed_data;
        s_tlast  <= t.last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_normals.push_back(face_normal(t));
        @(negedge clk);
    endtask

    function automatic tri_t random_triangle(input int style);
        tri_t t;
        for (int i = 0; i < 9; i++)
        begin
            unique case (style)
                0: t.v[i] = coord_t'($urandom);
                1: t.v[i] = coord_t'($signed($urandom_range(16)) - 8);
                default: t.v[i] = $urandom_range(1) ? coord_t'(32'h7fff - $urandom_range(3))
                                                     : coord_t'(32'h8000 + $urandom_range(3));
            endcase
        end
        // coincident second and third vertex
        if (style == 3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t.v[6 + i] = t.v[3 + i];
            end
        end
        t.last = 1'($urandom_range(1));
        return t;
    endfunction

    // Sender stops and waits for every outstanding result
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic test_directed;
        tri_t t;
        coord_t ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001};
        // axis-aligned unit triangles, normals +z, -z and +y
        t.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        t.last = 1'b0;
        send_triangle(t);
        t.v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        t.last = 1'b1;
        send_triangle(t);
        t.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        send_triangle(t);
        // coincident vertices: degenerate
        t.v = '{5, -7, 9, 5, -7, 9, 5, -7, 9};
        t.last = 1'b1;
        send_triangle(t);
        // collinear vertices
        t.v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
        t.last = 1'b0;
        send_triangle(t);
        // corners of the coordinate range
        for (int k = 0; k < 16; k++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                t.v[i] = ext[(k + i * (k / 4 + 1)) % 4];
            end
            t.last = k[0];
            send_triangle(t);
        end
        t.v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh7fff, 16'sh8000};
        send_triangle(t);
        t.v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh8000, 16'sh7fff};
        t.last = 1'b1;
        send_triangle(t);
    endtask

    task automatic test_random(input int count, input int src_pct, input int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        for (int n = 0; n < count; n++)
        begin
            send_triangle(random_triangle($urandom_range(9) < 6 ? 0
                                                                : int'($urandom_range(1, 3))));
        end
    endtask

    // Receiver holds off long enough to back the pipeline up
    task automatic test_backpressure;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_reqs++;
        for (int n = 0; n < 150; n++)
        begin
            send_triangle(random_triangle(0));
        end
    endtask

    // Sink: random stall pattern, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        normal_t want;
        norm_t   got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_normals.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                want = pending_normals.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    got = m_tdata[i * tfn_pkg::OUT_W +: tfn_pkg::OUT_W];
                    if (got !== want.n[i])
                    begin
                        report_mismatch($sformatf("norm[%0d]", i), got, want.n[i]);
                    end
                end
                if (m_tuser[0] !== want.degen)
                begin
                    report_mismatch("degenerate", m_tuser[0], want.degen);
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(500, 20, 85);
        // sender waits for the pipeline to empty
        drain();
        test_random(500, 85, 20);
        test_backpressure();
        test_random(450, 0, 0);
        drain();

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
